@@ design/tip_pkg.sv @@
// Shared types, unit tables and character constants for the time interval text parser.
`default_nettype none

package tip_pkg;

	localparam int NUM_UNITS = 10;
	localparam int NUM_W     = 31;
	localparam int MS_W      = 32;
	localparam int MULT_W    = 27;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	localparam logic [3:0]        ULEN_MAX   = 4'd15;
	localparam logic [NUM_W-1:0]  DAYS_MAX   = 31'd24;
	localparam logic [MULT_W-1:0] MS_PER_SEC = 27'd1000;
	localparam logic [MS_W-1:0]   LIMIT_MS   = 32'h8000_0000;

	// Unit words in order of priority, right aligned, first letter highest.
	localparam logic [95:0] UNIT_WORD [NUM_UNITS] = '{
		96'("days"), 96'("hours"), 96'("minutes"), 96'("mins"), 96'("seconds"),
		96'("secs"), 96'("milliseconds"), 96'("millisecs"), 96'("mseconds"),
		96'("msecs")
	};
	localparam logic [3:0] UNIT_LEN [NUM_UNITS] = '{
		4'd4, 4'd5, 4'd7, 4'd4, 4'd7, 4'd4, 4'd12, 4'd9, 4'd8, 4'd5
	};
	localparam logic [MULT_W-1:0] UNIT_MULT [NUM_UNITS] = '{
		27'd86400000, 27'd3600000, 27'd60000, 27'd60000, 27'd1000,
		27'd1000, 27'd1, 27'd1, 27'd1, 27'd1
	};

	typedef enum logic [3:0] {
		PH_LEAD1,
		PH_LEAD2,
		PH_NUM,
		PH_PUNCT1,
		PH_TAIL0,
		PH_UNIT,
		PH_SPACE1,
		PH_PUNCT2,
		PH_END
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       has_char;
		logic       last;
	} text_word_t;

	typedef struct packed {
		logic              ok;
		logic              value_written;
		logic signed [31:0] interval_ms;
	} result_word_t;

	// A byte after classification, as held in the queue.
	typedef struct packed {
		logic [7:0] lc;
		logic [3:0] dval;
		logic       has_char;
		logic       last;
		logic       is_nul;
		logic       is_space;
		logic       is_digit;
		logic       is_alpha;
		logic       is_pnm;
		logic       is_minus;
	} class_word_t;

	// Work handed from the sequencer to the accumulator for one word.
	typedef struct packed {
		logic              valid;
		logic              last;
		logic              a_en;
		logic [NUM_W-1:0]  a_num;
		logic [MULT_W-1:0] a_mult;
		logic              b_en;
		logic [NUM_W-1:0]  b_num;
		logic              failed;
		logic              units_known;
		logic              negative;
	} work_t;

endpackage

`default_nettype wire

@@ design/tip_if.sv @@
// Valid/ready channel interfaces for text words and result words.
`default_nettype none

interface tip_text_if;
	import tip_pkg::*;
	logic       valid;
	logic       ready;
	text_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tip_result_if;
	import tip_pkg::*;
	logic         valid;
	logic         ready;
	result_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/tip_front.sv @@
// Front end: takes text words and sorts each byte into its character classes.
`default_nettype none

module tip_front (
	tip_text_if.sink             text,
	input  wire logic            full,
	output logic                 push,
	output tip_pkg::class_word_t push_word
);
	import tip_pkg::*;

	logic [7:0] ch;
	logic       is_upper;
	logic       is_punct;

	assign ch         = text.data.ch;
	assign text.ready = !full;
	assign push       = text.valid && !full;

	always_comb begin
		is_upper = ch inside {[8'd65:8'd90]};
		is_punct = ch inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]};
		push_word.lc       = is_upper ? (ch | 8'h20) : ch;
		push_word.dval     = ch[3:0];
		push_word.has_char = text.data.has_char;
		push_word.last     = text.data.last;
		push_word.is_nul   = (ch == CH_NUL);
		push_word.is_space = ch inside {[8'd9:8'd13], 8'd32};
		push_word.is_digit = ch inside {[8'd48:8'd57]};
		push_word.is_alpha = is_upper || (ch inside {[8'd97:8'd122]});
		push_word.is_pnm   = is_punct && (ch != CH_MINUS);
		push_word.is_minus = (ch == CH_MINUS);
	end

endmodule

`default_nettype wire

@@ design/tip_queue.sv @@
// Short queue of classified words between the front end and the sequencer.
`default_nettype none

module tip_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire tip_pkg::class_word_t push_word,
	input  wire logic                 pop,
	output logic                      full,
	output logic                      empty,
	output tip_pkg::class_word_t      head
);
	import tip_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	class_word_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/tip_seq.sv @@
// Parse sequencer: walks the phases for one classified word per cycle while the queue holds a word and adv is high.
`default_nettype none

module tip_seq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 empty,
	input  wire tip_pkg::class_word_t head,
	output logic                      pop,
	output tip_pkg::work_t            work_s1
);
	import tip_pkg::*;

	typedef struct packed {
		logic              found;
		logic              days_fail;
		logic [MULT_W-1:0] mult;
	} resolve_t;

	typedef struct packed {
		logic             over;
		logic [NUM_W-1:0] value;
	} num_step_t;

	function automatic logic [NUM_UNITS-1:0] letter_keep(input logic [3:0] pos,
			input logic [7:0] lc);
		logic [NUM_UNITS-1:0] keep;
		logic [3:0]           off;
		keep = '0;
		for (int i = 0; i < NUM_UNITS; i++) begin
			off     = UNIT_LEN[i] - pos - 4'd1;
			keep[i] = (pos < UNIT_LEN[i]) && (UNIT_WORD[i][{off, 3'b000} +: 8] == lc);
		end
		return keep;
	endfunction

	function automatic resolve_t resolve_unit(input logic [NUM_UNITS-1:0] cand,
			input logic [NUM_W-1:0] num);
		resolve_t r;
		r = '0;
		// The lowest candidate wins, so it is visited last.
		for (int i = NUM_UNITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				r.found = 1'b1;
				r.mult  = UNIT_MULT[i];
			end
		end
		r.days_fail = cand[0] && (num > DAYS_MAX);
		return r;
	endfunction

	function automatic num_step_t num_step(input logic [NUM_W-1:0] num, input logic [3:0] d);
		logic [NUM_W+3:0] n;
		num_step_t        s;
		n       = {1'b0, num, 3'b000} + {3'b000, num, 1'b0} + (NUM_W + 4)'(d);
		s.over  = |n[NUM_W+3:NUM_W];
		s.value = n[NUM_W-1:0];
		return s;
	endfunction

	phase_t               phase_q, phase_d;
	logic                 neg_q, neg_d;
	logic [NUM_W-1:0]     cur_q, cur_d;
	logic                 known_q, known_d;
	logic [3:0]           ulen_q, ulen_d;
	logic [NUM_UNITS-1:0] cand_q, cand_d;
	logic                 failed_q, failed_d;
	logic                 go;
	logic                 fin;
	resolve_t             rs_feed, rs_fin;
	num_step_t            ns;
	work_t                work_d;

	assign pop = adv && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD1;
			neg_q    <= 1'b0;
			cur_q    <= '0;
			known_q  <= 1'b1;
			ulen_q   <= '0;
			cand_q   <= '1;
			failed_q <= 1'b0;
			work_s1  <= '0;
		end else if (adv) begin
			if (pop) begin
				phase_q  <= phase_d;
				neg_q    <= neg_d;
				cur_q    <= cur_d;
				known_q  <= known_d;
				ulen_q   <= ulen_d;
				cand_q   <= cand_d;
				failed_q <= failed_d;
			end
			work_s1 <= work_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		neg_d    = neg_q;
		cur_d    = cur_q;
		known_d  = known_q;
		ulen_d   = ulen_q;
		cand_d   = cand_q;
		failed_d = failed_q;
		go       = 1'b0;
		fin      = 1'b0;
		work_d   = '0;
		rs_feed  = resolve_unit(cand_q, cur_q);
		ns       = num_step(cur_q, head.dval);

		if (head.has_char && phase_q != PH_END) begin
			if (head.is_nul) begin
				fin = 1'b1;
			end else begin
				go = 1'b1;
			end
		end

		// A byte may pass through several phases; the phases are visited in order.
		if (go && phase_d == PH_LEAD1) begin
			if (head.is_space) begin
				go = 1'b0;
			end else begin
				phase_d = PH_LEAD2;
				if (head.is_minus) begin
					neg_d = 1'b1;
					go    = 1'b0;
				end
			end
		end
		if (go && phase_d == PH_LEAD2) begin
			if (head.is_space) begin
				go = 1'b0;
			end else if (head.is_digit) begin
				cur_d   = '0;
				phase_d = PH_NUM;
			end else begin
				failed_d = 1'b1;
				phase_d  = PH_END;
				go       = 1'b0;
			end
		end
		if (go && phase_d == PH_NUM) begin
			if (head.is_digit) begin
				// Entered from the lead phases the number is zero and cannot overflow.
				if (phase_q == PH_NUM && ns.over) begin
					failed_d = 1'b1;
					phase_d  = PH_END;
				end else if (phase_q == PH_NUM) begin
					cur_d = ns.value;
				end else begin
					cur_d = NUM_W'(head.dval);
				end
				go = 1'b0;
			end else begin
				phase_d = PH_PUNCT1;
			end
		end
		if (go && phase_d == PH_PUNCT1) begin
			if (head.is_pnm) begin
				go = 1'b0;
			end else if (head.is_alpha) begin
				ulen_d  = '0;
				cand_d  = '1;
				phase_d = PH_UNIT;
			end else begin
				phase_d = PH_TAIL0;
			end
		end
		if (go && phase_d == PH_TAIL0) begin
			if (!head.is_space) begin
				failed_d = 1'b1;
				phase_d  = PH_END;
			end
			go = 1'b0;
		end
		if (go && phase_d == PH_UNIT) begin
			if (head.is_alpha) begin
				cand_d = cand_d & letter_keep(ulen_d, head.lc);
				if (ulen_d != ULEN_MAX) begin
					ulen_d = ulen_d + 4'd1;
				end
				go = 1'b0;
			end else if (rs_feed.days_fail) begin
				failed_d = 1'b1;
				phase_d  = PH_END;
				go       = 1'b0;
			end else begin
				if (rs_feed.found) begin
					work_d.a_en   = 1'b1;
					work_d.a_num  = cur_q;
					work_d.a_mult = rs_feed.mult;
				end else begin
					known_d = 1'b0;
				end
				phase_d = PH_SPACE1;
			end
		end
		if (go && phase_d == PH_SPACE1) begin
			if (head.is_space) begin
				go = 1'b0;
			end else begin
				phase_d = PH_PUNCT2;
			end
		end
		if (go && phase_d == PH_PUNCT2) begin
			if (head.is_pnm) begin
				go = 1'b0;
			end else if (head.is_digit) begin
				phase_d = PH_NUM;
			end else begin
				failed_d = 1'b1;
				phase_d  = PH_END;
				go       = 1'b0;
			end
		end
		if (go && phase_d == PH_NUM) begin
			// Coming back from the separator phases: a fresh number starts here.
			cur_d = NUM_W'(head.dval);
			go    = 1'b0;
		end

		// End of text, by a NUL byte or by the last flag.
		rs_fin = resolve_unit(cand_d, cur_d);
		if ((fin || head.last) && phase_d != PH_END) begin
			case (phase_d)
				PH_LEAD1, PH_LEAD2: begin
					failed_d = 1'b1;
				end
				PH_NUM, PH_PUNCT1, PH_TAIL0: begin
					work_d.b_en  = 1'b1;
					work_d.b_num = cur_d;
					known_d      = 1'b1;
				end
				PH_UNIT: begin
					if (rs_fin.days_fail) begin
						failed_d = 1'b1;
					end else if (rs_fin.found) begin
						work_d.a_en   = 1'b1;
						work_d.a_num  = cur_d;
						work_d.a_mult = rs_fin.mult;
					end else begin
						known_d = 1'b0;
					end
				end
				default: begin
				end
			endcase
			phase_d = PH_END;
		end

		work_d.valid       = pop;
		work_d.last        = head.last;
		work_d.failed      = failed_d;
		work_d.units_known = known_d;
		work_d.negative    = neg_d;
		if (!pop) begin
			work_d = '0;
		end

		if (head.last) begin
			phase_d  = PH_LEAD1;
			neg_d    = 1'b0;
			cur_d    = '0;
			known_d  = 1'b1;
			ulen_d   = '0;
			cand_d   = '1;
			failed_d = 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ design/tip_acc.sv @@
// Back end: multiplies the unit amounts, sums milliseconds and holds the result word.
`default_nettype none

module tip_acc (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tip_pkg::work_t work_s1,
	output logic                adv,
	tip_result_if.source        result
);
	import tip_pkg::*;

	logic              valid_s2, last_s2;
	logic              failed_s2, known_s2, neg_s2;
	logic [MS_W-1:0]   prod_a_s2, prod_b_s2;
	logic [MS_W-1:0]   total_q;
	logic [MS_W-1:0]   sum;
	logic              res_valid_s3;
	logic [MS_W-1:0]   res_total_s3;
	logic              res_failed_s3, res_known_s3, res_neg_s3;
	logic              out_valid_q;
	result_word_t      out_q;
	logic              written;
	logic [MS_W-1:0]   magnitude;

	assign adv          = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;
	assign sum          = total_q + prod_a_s2 + prod_b_s2;
	assign written      = (res_total_s3 <= LIMIT_MS);
	assign magnitude    = res_neg_s3 ? (~res_total_s3 + 1'b1) : res_total_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_a_s2 <= work_s1.a_en ? (MS_W'(work_s1.a_num) * MS_W'(work_s1.a_mult)) : '0;
			prod_b_s2 <= work_s1.b_en ? (MS_W'(work_s1.b_num) * MS_W'(MS_PER_SEC)) : '0;
			last_s2   <= work_s1.last;
			failed_s2 <= work_s1.failed;
			known_s2  <= work_s1.units_known;
			neg_s2    <= work_s1.negative;
			if (valid_s2 && last_s2) begin
				res_total_s3  <= sum;
				res_failed_s3 <= failed_s2;
				res_known_s3  <= known_s2;
				res_neg_s3    <= neg_s2;
			end
			if (res_valid_s3) begin
				out_q.ok            <= written && !res_failed_s3 && res_known_s3;
				out_q.value_written <= written;
				out_q.interval_ms   <= written ? $signed(magnitude) : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			total_q      <= '0;
			res_valid_s3 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s2     <= work_s1.valid;
			res_valid_s3 <= valid_s2 && last_s2;
			out_valid_q  <= res_valid_s3;
			if (valid_s2) begin
				total_q <= last_s2 ? '0 : sum;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/time_interval_text_parser.sv @@
// Top level of the time interval text parser: front end, queue, sequencer and accumulator.
`default_nettype none

//  Channel | Direction | Payload                               | Handshake
//  --------+-----------+---------------------------------------+-------------
//  text    | in        | ch[7:0], has_char, last               | valid/ready
//  result  | out       | ok, value_written, interval_ms[31:0]  | valid/ready
//
// One text word is taken every clock cycle while the queue has room; the sequencer
// retires one word per cycle unless a result word is held at the output, so the
// sustained rate is one word per cycle. The word flagged last is written to the queue
// at the accepting edge, then passes the sequencer register, the product register, the
// sum register and the output register, from which its result word is presented.
// Reset clears every control register at once; there is no clearing pass.
// While a result word waits at the output the back end holds still and the queue
// keeps taking text words until it is full, QUEUE_DEPTH words deep.

module time_interval_text_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tip_text_if.sink     text,
	tip_result_if.source result
);
	import tip_pkg::*;

	// Front end: classify each byte and push it into the queue when there is room.
	logic        push;
	class_word_t push_word;
	logic        full;
	logic        empty;
	logic        pop;
	class_word_t head;
	logic        adv;
	work_t       work_s1;

	tip_front u_front (
		.text      (text),
		.full      (full),
		.push      (push),
		.push_word (push_word)
	);

	// The queue decouples the accepting side from the parsing side.
	tip_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.head      (head)
	);

	// The sequencer holds the parse state and turns each word into work for the
	// accumulator: at most one unit amount and one bare seconds amount per word.
	tip_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.empty   (empty),
		.head    (head),
		.pop     (pop),
		.work_s1 (work_s1)
	);

	// The accumulator multiplies, sums modulo 2^32 and forms the signed result;
	// its output register gates the whole back end through adv.
	tip_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.work_s1 (work_s1),
		.adv     (adv),
		.result  (result)
	);

endmodule

`default_nettype wire
